>>> rtl/siit_pkg.sv
package siit_pkg;

    localparam int CAPACITY   = 256;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int DATA_W     = 32;
    localparam int RIDX_W     = 8;
    localparam int POS_W      = 9;
    localparam int GROUP_SIZE = 16;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_INVALID   = 3'd1,
        ST_FULL      = 3'd2,
        ST_READ_OK   = 3'd3,
        ST_BAD_INDEX = 3'd4
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] payload;
        logic [DATA_W-1:0] end_pos;
        logic [DATA_W-1:0] start_pos;
    } entry_t;

    // control from the sequencer to every cell
    typedef struct packed {
        entry_t new_entry;
        logic   insert_en;
    } cell_ctrl_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        entry_t           entry;
    } sel_word_t;

    // input tdata, lowest field in the lowest bits
    typedef struct packed {
        logic [RIDX_W-1:0] read_index;
        logic [DATA_W-1:0] payload;
        logic [DATA_W-1:0] end_position;
        logic [DATA_W-1:0] start_position;
    } in_word_t;

    // output tdata, lowest field in the lowest bits
    typedef struct packed {
        logic [2:0]        pad;
        logic [DATA_W-1:0] out_payload;
        logic [DATA_W-1:0] out_end;
        logic [DATA_W-1:0] out_start;
        logic [POS_W-1:0]  entry_count;
        logic [POS_W-1:0]  position;
        status_t           status;
    } out_word_t;

    localparam int IN_W  = $bits(in_word_t);
    localparam int OUT_W = $bits(out_word_t);

endpackage

>>> rtl/siit_cell.sv
module siit_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  siit_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                prev_less,
    input  siit_pkg::entry_t    prev_entry,
    output logic                less,
    output siit_pkg::entry_t    entry
);
    import siit_pkg::*;

    entry_t entry_reg;
    logic   less_reg;
    logic   less_next;

    // stored entry orders strictly before the new interval
    assign less_next = occupied &&
        ((entry_reg.start_pos < ctrl.new_entry.start_pos) ||
         ((entry_reg.start_pos == ctrl.new_entry.start_pos) &&
          (entry_reg.end_pos < ctrl.new_entry.end_pos)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            less_reg <= 1'b0;
        end
        else
        begin
            less_reg <= less_next;
        end
    end

    // keep below the boundary, take the new entry at it, shift up above it
    always_ff @(posedge clk)
    begin
        if (ctrl.insert_en && !less_reg)
        begin
            entry_reg <= prev_less ? ctrl.new_entry : prev_entry;
        end
    end

    assign less  = less_reg;
    assign entry = entry_reg;

endmodule

>>> rtl/siit_sel_tree.sv
module siit_sel_tree (
    input  logic                clk,
    input  logic                capture,
    input  siit_pkg::sel_word_t words [siit_pkg::CAPACITY],
    output siit_pkg::sel_word_t result
);
    import siit_pkg::*;

    sel_word_t group_reg  [NUM_GROUPS];
    sel_word_t group_next [NUM_GROUPS];

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < CAPACITY)
                begin
                    group_next[g] = group_next[g] | words[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            group_reg <= group_next;
        end
    end

    always_comb
    begin
        result = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            result = result | group_reg[g];
        end
    end

endmodule

>>> rtl/sorted_interval_insert_table_core.sv
// Channel   Dir  Width  Contents
// s_*       in   104    tdata: start, end, payload, read_index; tuser: mode
// m_*       out  120    tdata: status, position, count, start, end, payload
//
// Each item passes in order through capture, compare in every cell, shift or
// select, then gather through a two-level registered select tree.
// An insert shifts all cells above the landing slot together.
// Reset clears the entry count and control; cell contents stay undefined.
// A new item is taken while a result waits; a stalled result holds the
// next one in the gather step.
module sorted_interval_insert_table_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // start_position, end_position, payload, read_index
    input  logic [siit_pkg::IN_W-1:0]   s_tdata,
    // mode
    input  logic [0:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // status, position, entry_count, out_start, out_end, out_payload
    output logic [siit_pkg::OUT_W-1:0]  m_tdata
);
    import siit_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SHIFT,
        S_SUM
    } state_t;

    state_t            state_reg;
    logic              mode_reg;
    entry_t            cmd_entry_reg;
    logic [RIDX_W-1:0] cmd_ridx_reg;
    logic [CNT_W-1:0]  count_reg;
    status_t           status_reg;
    logic              m_tvalid_reg;
    out_word_t         out_reg;

    in_word_t   in_word;
    status_t    status_next;
    out_word_t  out_next;
    logic       bad_interval;
    logic       table_full;
    logic       read_ok;
    logic       insert_ok;
    logic       out_free;
    cell_ctrl_t ctrl;
    sel_word_t  result;

    logic      less      [CAPACITY];
    logic      prev_less [CAPACITY];
    entry_t    entries   [CAPACITY];
    entry_t    prev_ent  [CAPACITY];
    logic      occupied  [CAPACITY];
    sel_word_t words     [CAPACITY];

    assign in_word      = in_word_t'(s_tdata);
    assign s_tready     = (state_reg == S_IDLE);
    assign out_free     = !m_tvalid_reg || m_tready;

    assign bad_interval = cmd_entry_reg.start_pos > cmd_entry_reg.end_pos;
    assign table_full   = count_reg >= CNT_W'(CAPACITY);
    assign read_ok      = CNT_W'(cmd_ridx_reg) < count_reg;
    assign insert_ok    = !mode_reg && !bad_interval && !table_full;

    assign ctrl.new_entry = cmd_entry_reg;
    assign ctrl.insert_en = (state_reg == S_SHIFT) && insert_ok;

    always_comb
    begin
        if (mode_reg)
        begin
            status_next = read_ok ? ST_READ_OK : ST_BAD_INDEX;
        end
        else if (bad_interval)
        begin
            status_next = ST_INVALID;
        end
        else if (table_full)
        begin
            status_next = ST_FULL;
        end
        else
        begin
            status_next = ST_INSERTED;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                assign prev_less[i] = 1'b1;
                assign prev_ent[i]  = '0;
            end
            else
            begin : g_rest
                assign prev_less[i] = less[i-1];
                assign prev_ent[i]  = entries[i-1];
            end

            assign occupied[i] = CNT_W'(i) < count_reg;

            siit_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .occupied   (occupied[i]),
                .prev_less  (prev_less[i]),
                .prev_entry (prev_ent[i]),
                .less       (less[i]),
                .entry      (entries[i])
            );

            // insert: the landing slot answers; read: the addressed slot answers
            always_comb
            begin
                words[i] = '0;
                if (mode_reg ? (CNT_W'(cmd_ridx_reg) == CNT_W'(i))
                             : (!less[i] && prev_less[i]))
                begin
                    words[i].idx   = IDX_W'(i);
                    words[i].entry = entries[i];
                end
            end
        end
    endgenerate

    siit_sel_tree u_sel_tree (
        .clk     (clk),
        .capture (state_reg == S_SHIFT),
        .words   (words),
        .result  (result)
    );

    always_comb
    begin
        out_next             = '0;
        out_next.status      = status_reg;
        out_next.entry_count = POS_W'(count_reg);
        case (status_reg)
            ST_INSERTED:  out_next.position = POS_W'(result.idx);
            ST_READ_OK:
            begin
                out_next.position    = POS_W'(cmd_ridx_reg);
                out_next.out_start   = result.entry.start_pos;
                out_next.out_end     = result.entry.end_pos;
                out_next.out_payload = result.entry.payload;
            end
            ST_BAD_INDEX: out_next.position = POS_W'(cmd_ridx_reg);
            default:      out_next.position = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= 1'b0;
            cmd_entry_reg <= '0;
            cmd_ridx_reg  <= '0;
            count_reg     <= '0;
            status_reg    <= ST_INSERTED;
            m_tvalid_reg  <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // drop valid once taken, unless the gather step refills it
            if (m_tvalid_reg && m_tready && (state_reg != S_SUM))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        mode_reg                <= s_tuser[0];
                        cmd_entry_reg.start_pos <= in_word.start_position;
                        cmd_entry_reg.end_pos   <= in_word.end_position;
                        cmd_entry_reg.payload   <= in_word.payload;
                        cmd_ridx_reg            <= in_word.read_index;
                        state_reg               <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    status_reg <= status_next;
                    if (insert_ok)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    // hold here while the previous result is still pending
                    if (out_free)
                    begin
                        out_reg      <= out_next;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule

>>> rtl/siit_checker.sv
module siit_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [siit_pkg::OUT_W-1:0]  m_tdata
);
    import siit_pkg::*;

    out_word_t ow;

    assign ow = out_word_t'(m_tdata);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // data fields are zero unless the read hit a stored entry
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ow.status != ST_READ_OK |->
            ow.out_start == '0 && ow.out_end == '0 && ow.out_payload == '0)
        else $error("data fields set on a result without a read");

    // an inserted slot lies below the new count, and the count is nonzero
    a_insert_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ow.status == ST_INSERTED |->
            ow.position < ow.entry_count)
        else $error("insert position not below entry count");

    // a read that hits lies below the count
    a_read_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ow.status == ST_READ_OK |->
            ow.position < ow.entry_count)
        else $error("read hit beyond entry count");

endmodule

bind sorted_interval_insert_table_core siit_checker u_siit_checker (.*);

>>> verif/siit_tb_pkg.sv
`timescale 1ns / 100ps

package siit_tb_pkg;
    import siit_pkg::*;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    class interval_table_scoreboard;
        logic [DATA_W-1:0] tbl_start   [CAPACITY];
        logic [DATA_W-1:0] tbl_end     [CAPACITY];
        logic [DATA_W-1:0] tbl_payload [CAPACITY];
        int                fill;
        int                errors;
        out_word_t         expected_responses [$];

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // Apply one accepted input transaction to the table copy and queue its response.
        function void note_request(logic mode, in_word_t w);
            out_word_t r;
            int        k;
            int        j;
            r = '0;
            r.status = ST_INSERTED;
            if (mode == MODE_INSERT)
            begin
                if (w.start_position > w.end_position)
                begin
                    r.status = ST_INVALID;
                end
                else if (fill >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // land ahead of any equal entries
                    k = 0;
                    while (k < fill && (tbl_start[k] < w.start_position ||
                           (tbl_start[k] == w.start_position &&
                            tbl_end[k] < w.end_position)))
                        k++;
                    for (j = fill; j > k; j--)
                    begin
                        tbl_start[j]   = tbl_start[j-1];
                        tbl_end[j]     = tbl_end[j-1];
                        tbl_payload[j] = tbl_payload[j-1];
                    end
                    tbl_start[k]   = w.start_position;
                    tbl_end[k]     = w.end_position;
                    tbl_payload[k] = w.payload;
                    fill++;
                    r.position = POS_W'(k);
                end
            end
            else
            begin
                r.position = POS_W'(w.read_index);
                if (int'(w.read_index) < fill)
                begin
                    r.status      = ST_READ_OK;
                    r.out_start   = tbl_start[w.read_index];
                    r.out_end     = tbl_end[w.read_index];
                    r.out_payload = tbl_payload[w.read_index];
                end
                else
                begin
                    r.status = ST_BAD_INDEX;
                end
            end
            r.entry_count = POS_W'(fill);
            expected_responses.insert(expected_responses.size(), r);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (expected_responses.size() == 0)
            begin
                $error("result with nothing outstanding: status %0d position %0d",
                       got.status, got.position);
                errors++;
                return;
            end
            want = expected_responses.pop_front();
            compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
            compare_field("position", DATA_W'(want.position), DATA_W'(got.position));
            compare_field("entry_count", DATA_W'(want.entry_count),
                          DATA_W'(got.entry_count));
            compare_field("out_start", want.out_start, got.out_start);
            compare_field("out_end", want.out_end, got.out_end);
            compare_field("out_payload", want.out_payload, got.out_payload);
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        function void flush_leftover();
            out_word_t want;
            while (expected_responses.size() != 0)
            begin
                want = expected_responses.pop_front();
                $error("result never arrived: status %0d position %0d",
                       want.status, want.position);
                errors++;
            end
        endfunction
    endclass

endpackage

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import siit_pkg::*;
    import siit_tb_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 410;
    localparam int DRAIN_CYCLES = 20;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic [0:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    interval_table_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit rx_hold_req = 1'b0;
    int idle_cycles = 0;

    sorted_interval_insert_table_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold valid between back-to-back items; drop it only for an idle gap.
    task automatic send_item(logic mode, in_word_t w);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= w;
        do @(posedge clk); while (!s_tready);
        sb.note_request(mode, w);
    endtask

    task automatic send_insert(logic [DATA_W-1:0] s, logic [DATA_W-1:0] e,
                               logic [DATA_W-1:0] p);
        in_word_t w;
        w = '0;
        w.start_position = s;
        w.end_position   = e;
        w.payload        = p;
        send_item(MODE_INSERT, w);
    endtask

    task automatic send_read(int idx);
        in_word_t w;
        w = '0;
        w.read_index = RIDX_W'(idx);
        send_item(MODE_READ, w);
    endtask

    // Narrow pools make equal starts and ends common.
    function automatic logic [DATA_W-1:0] pick_coord();
        case ($urandom_range(3))
            0:       return DATA_W'($urandom_range(15));
            1:       return {DATA_W{1'b1}} - DATA_W'($urandom_range(15));
            2:       return $urandom();
            default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    task automatic send_random_item();
        in_word_t          w;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        w = '0;
        w.payload    = $urandom();
        w.read_index = RIDX_W'($urandom_range(255));
        if ($urandom_range(99) < 40)
        begin
            a = pick_coord();
            b = pick_coord();
            // keep most intervals well ordered
            if (a > b && $urandom_range(99) < 85)
            begin
                w.start_position = b;
                w.end_position   = a;
            end
            else
            begin
                w.start_position = a;
                w.end_position   = b;
            end
            send_item(MODE_INSERT, w);
        end
        else
        begin
            if (sb.fill > 0 && $urandom_range(1))
                w.read_index = RIDX_W'($urandom_range(sb.fill - 1));
            w.start_position = $urandom();
            w.end_position   = $urandom();
            send_item(MODE_READ, w);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $error("no transaction for %0d cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        sb       = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, rejected intervals, extremes and equal entries
        rx_idle_pct = 30;
        send_read(0);
        send_read(255);
        send_insert(32'd1, 32'd0, 32'hdead_beef);
        send_insert(32'hffff_ffff, 32'd0, 32'h0);
        send_insert(32'd0, 32'd0, 32'h0);
        send_insert(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_insert(32'd0, 32'hffff_ffff, 32'ha5a5_a5a5);
        send_insert(32'd0, 32'd0, 32'h1234_5678);
        send_insert(32'd5, 32'd9, 32'd1);
        send_insert(32'd5, 32'd7, 32'd2);
        send_insert(32'd5, 32'd9, 32'd3);
        send_insert(32'h8000_0000, 32'h8000_0000, 32'h5a5a_5a5a);
        for (int i = 0; i <= 8; i++)
            send_read(i);
        send_read(128);
        wait_drained();

        tx_idle_pct = 18;
        rx_idle_pct = 72;
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_item();
        wait_drained();

        tx_idle_pct = 72;
        rx_idle_pct = 18;
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_item();
        wait_drained();

        // long receiver stall while items keep coming, then full speed
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_item();
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.flush_leftover();
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
rtl/siit_pkg.sv
rtl/siit_cell.sv
rtl/siit_sel_tree.sv
rtl/sorted_interval_insert_table_core.sv
rtl/siit_checker.sv
verif/siit_tb_pkg.sv
verif/tb_top.sv
